@@ rtl/mvdh_pkg.sv @@
package mvdh_pkg;

  localparam int MAX_CELLS  = 4096;
  localparam int ADDR_W     = 12;
  localparam int CNT_W      = 13;
  localparam int VAL_W      = 33;
  localparam int NUM_W      = 38;
  localparam int Q_W        = 6;
  localparam int VALUE_BINS = 32;
  localparam int DELTA_BINS = 64;
  localparam int VBIN_W     = 5;
  localparam int DBIN_W     = 6;

  typedef enum logic [1:0] {
    REG_CELL_BYTES  = 2'd0,
    REG_CELL_SIGNED = 2'd1,
    REG_MAP_COLS    = 2'd2,
    REG_MAP_ROWS    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
    logic           rem_nz;
  } div_res_t;

endpackage

@@ rtl/map_value_delta_histogram_unit.sv @@
// Map value and delta histogram unit.
// Cells enter on the command channel: a cell transfers at a rising edge with
// start high and busy low. Cells are stored up to 4096; later ones set overflow.
// The cell that carries last_cell starts the binning pass; busy stays high
// until the whole map has been reported.
// Binning runs on one shared restoring divider (six quotient steps) under a
// sequencer: one division per stored cell for the value histogram and one
// per delta (two reads of the cell memory, division, read-modify-write of
// the delta bin memory). Then 64 results follow on consecutive cycles, one
// per bin, each marked by result_valid for exactly one cycle; last_result
// marks bin 63. The receiver cannot stall, so each result must be taken in
// its cycle. After the final result the map state clears and busy falls.
// Registers are written on the cfg channel (always ready); the user must
// write them only while busy is low, which the block does not enforce.
// Synchronous reset restores register defaults and empties the map; the
// cell memory needs no clearing.
module map_value_delta_histogram_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 cell_value,
  input  logic                        last_cell,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [12:0]                 cfg_data,
  output logic                        result_valid,
  output logic [5:0]                  bin_index,
  output logic [12:0]                 value_count,
  output logic [12:0]                 delta_count,
  output logic [12:0]                 cell_total,
  output logic [12:0]                 delta_total,
  output logic                        overflow,
  output logic                        last_result
);

  typedef enum logic [14:0] {
    IDLE   = 15'b000000000000001,
    RANGE  = 15'b000000000000010,
    VRD    = 15'b000000000000100,
    VSUB   = 15'b000000000001000,
    VSTART = 15'b000000000010000,
    VWAIT  = 15'b000000000100000,
    DRDA   = 15'b000000001000000,
    DRDB   = 15'b000000010000000,
    DSUB   = 15'b000000100000000,
    DSTART = 15'b000001000000000,
    DWAIT  = 15'b000010000000000,
    DINC1  = 15'b000100000000000,
    DINC2  = 15'b001000000000000,
    EMIT   = 15'b010000000000000,
    DONE   = 15'b100000000000000
  } state_t;

  state_t state;

  logic [2:0]  cell_bytes;
  logic        cell_signed;
  logic [12:0] map_cols;
  logic [12:0] map_rows;

  logic [mvdh_pkg::CNT_W-1:0] cells_loaded;
  logic [mvdh_pkg::CNT_W-1:0] deltas_counted;
  logic                       dropped;
  logic signed [mvdh_pkg::VAL_W-1:0] min_seen;
  logic signed [mvdh_pkg::VAL_W-1:0] max_seen;

  logic [mvdh_pkg::CNT_W-1:0] idx;
  logic [mvdh_pkg::CNT_W-1:0] idx_end;
  logic [mvdh_pkg::CNT_W-1:0] lim_q;
  logic                       vert_q;
  logic [mvdh_pkg::VAL_W-1:0] range_q;
  logic [mvdh_pkg::VAL_W-1:0] x_q;
  logic signed [mvdh_pkg::VAL_W-1:0] va_q;
  logic signed [mvdh_pkg::VAL_W:0]   d_q;
  logic [mvdh_pkg::DBIN_W-1:0] dbin_q;
  logic [mvdh_pkg::DBIN_W-1:0] k;

  logic [mvdh_pkg::VAL_W-1:0] cmem [mvdh_pkg::MAX_CELLS];
  logic [mvdh_pkg::VAL_W-1:0] crd_q;
  logic [mvdh_pkg::CNT_W-1:0] dmem [mvdh_pkg::DELTA_BINS];
  logic [mvdh_pkg::CNT_W-1:0] drd_q;
  logic                       dvb_q;
  logic [mvdh_pkg::DELTA_BINS-1:0] dvalid;
  logic [mvdh_pkg::CNT_W-1:0] value_bins [mvdh_pkg::VALUE_BINS];

  logic [5:0]  bin_q;
  logic [12:0] val_q;
  logic        res_v;
  logic        last_q;

  logic signed [mvdh_pkg::VAL_W-1:0] dec;
  logic        accept;
  logic        store_ok;
  logic [mvdh_pkg::CNT_W-1:0] addr_b;
  logic [mvdh_pkg::ADDR_W-1:0] craddr;
  logic        crd_en;
  logic [mvdh_pkg::DBIN_W-1:0] draddr;
  logic        drd_en;
  logic [25:0] prod;
  logic [mvdh_pkg::CNT_W-1:0] lim;
  logic        succ_en;
  logic        vert_en;
  logic [mvdh_pkg::VAL_W:0]   diff_mm;
  logic [mvdh_pkg::VAL_W:0]   diff_x;
  logic [mvdh_pkg::VAL_W:0]   dabs;
  logic [mvdh_pkg::NUM_W-1:0] vnum;
  logic [mvdh_pkg::NUM_W-1:0] dnum;
  logic        div_start;
  logic [mvdh_pkg::NUM_W-1:0] div_num;
  mvdh_pkg::div_res_t div_res;
  logic [6:0]  qc;
  logic [6:0]  dbin7;
  logic [mvdh_pkg::CNT_W-1:0] idx_inc;
  logic        vert_go;

  always_comb begin
    unique case (cell_bytes)
      3'd0: dec = '0;
      3'd1: dec = (cell_signed && cell_value[7]) ? {{25{1'b1}}, cell_value[7:0]}
                                                 : {25'b0, cell_value[7:0]};
      3'd2: dec = (cell_signed && cell_value[15]) ? {{17{1'b1}}, cell_value[15:0]}
                                                  : {17'b0, cell_value[15:0]};
      3'd3: dec = {9'b0, cell_value[23:0]};
      3'd4: dec = {cell_signed & cell_value[31], cell_value};
      default: dec = {1'b0, cell_value};
    endcase
  end

  assign busy      = (state != IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign store_ok  = (cells_loaded < mvdh_pkg::CNT_W'(mvdh_pkg::MAX_CELLS));

  assign prod    = {13'b0, map_rows} * {13'b0, map_cols};
  assign lim     = (prod > {13'b0, cells_loaded}) ? cells_loaded : prod[12:0];
  assign succ_en = (map_cols > 13'd1) || (map_rows > 13'd1);
  assign vert_en = (map_cols != 13'd0) && (map_rows > 13'd1);
  assign vert_go = vert_en && (map_cols < lim_q);
  assign idx_inc = idx + 13'd1;

  assign diff_mm = {max_seen[32], max_seen} - {min_seen[32], min_seen};
  assign diff_x  = {1'b0, crd_q} - {min_seen[32], min_seen};
  assign vnum    = {x_q, 5'b0} - {5'b0, x_q};
  assign dabs    = d_q[33] ? (34'd0 - d_q) : d_q;
  assign dnum    = {1'b0, dabs[32:0], 4'b0};

  assign div_start = (state == VSTART) || (state == DSTART);
  assign div_num   = (state == VSTART) ? vnum : dnum;

  assign qc    = {1'b0, div_res.quot} + {6'b0, div_res.rem_nz};
  assign dbin7 = d_q[33] ? (7'd32 - qc) : (7'd32 + {1'b0, div_res.quot});

  assign addr_b = vert_q ? (idx - map_cols) : (idx - 13'd1);
  assign craddr = (state == DRDB) ? addr_b[mvdh_pkg::ADDR_W-1:0]
                                  : idx[mvdh_pkg::ADDR_W-1:0];
  assign crd_en = (state == VRD) || (state == DRDA) || (state == DRDB);
  assign draddr = (state == EMIT) ? k : dbin_q;
  assign drd_en = (state == EMIT) || (state == DINC1);

  mvdh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (range_q),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_bytes  <= 3'd1;
      cell_signed <= 1'b0;
      map_cols    <= '0;
      map_rows    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mvdh_pkg::reg_index_t'(cfg_index))
        mvdh_pkg::REG_CELL_BYTES:  cell_bytes  <= cfg_data[2:0];
        mvdh_pkg::REG_CELL_SIGNED: cell_signed <= cfg_data[0];
        mvdh_pkg::REG_MAP_COLS:    map_cols    <= cfg_data;
        mvdh_pkg::REG_MAP_ROWS:    map_rows    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      cmem[cells_loaded[mvdh_pkg::ADDR_W-1:0]] <= dec;
    end
    if (crd_en) begin
      crd_q <= cmem[craddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == DINC2) begin
      dmem[dbin_q] <= (dvb_q ? drd_q : 13'd0) + 13'd1;
    end
    if (drd_en) begin
      drd_q <= dmem[draddr];
      dvb_q <= dvalid[draddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      cells_loaded   <= '0;
      deltas_counted <= '0;
      dropped        <= 1'b0;
      min_seen       <= {1'b0, {32{1'b1}}};
      max_seen       <= {1'b1, 32'b0};
      dvalid         <= '0;
      res_v          <= 1'b0;
      last_q         <= 1'b0;
      idx            <= '0;
      k              <= '0;
      for (int j = 0; j < mvdh_pkg::VALUE_BINS; j++) begin
        value_bins[j] <= '0;
      end
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (store_ok) begin
              cells_loaded <= cells_loaded + 13'd1;
              if (dec < min_seen) min_seen <= dec;
              if (dec > max_seen) max_seen <= dec;
            end else begin
              dropped <= 1'b1;
            end
            if (last_cell) state <= RANGE;
          end
        end
        RANGE: begin
          range_q <= (diff_mm[32:0] == '0) ? 33'd1 : diff_mm[32:0];
          lim_q   <= lim;
          idx     <= '0;
          state   <= VRD;
        end
        VRD: state <= VSUB;
        VSUB: begin
          x_q   <= diff_x[32:0];
          state <= VSTART;
        end
        VSTART: state <= VWAIT;
        VWAIT: begin
          if (div_res.done) begin
            value_bins[div_res.quot[mvdh_pkg::VBIN_W-1:0]] <=
              value_bins[div_res.quot[mvdh_pkg::VBIN_W-1:0]] + 13'd1;
            if (idx_inc == cells_loaded) begin
              if (succ_en && cells_loaded > 13'd1) begin
                vert_q  <= 1'b0;
                idx     <= 13'd1;
                idx_end <= cells_loaded;
                state   <= DRDA;
              end else if (vert_go) begin
                vert_q  <= 1'b1;
                idx     <= map_cols;
                idx_end <= lim_q;
                state   <= DRDA;
              end else begin
                k     <= '0;
                state <= EMIT;
              end
            end else begin
              idx   <= idx_inc;
              state <= VRD;
            end
          end
        end
        DRDA: state <= DRDB;
        DRDB: begin
          va_q  <= crd_q;
          state <= DSUB;
        end
        DSUB: begin
          d_q   <= {va_q[32], va_q} - {crd_q[32], crd_q};
          state <= DSTART;
        end
        DSTART: state <= DWAIT;
        DWAIT: begin
          if (div_res.done) begin
            dbin_q <= dbin7[5:0];
            state  <= DINC1;
          end
        end
        DINC1: state <= DINC2;
        DINC2: begin
          dvalid[dbin_q] <= 1'b1;
          deltas_counted <= deltas_counted + 13'd1;
          if (idx_inc == idx_end) begin
            if (!vert_q && vert_go) begin
              vert_q  <= 1'b1;
              idx     <= map_cols;
              idx_end <= lim_q;
              state   <= DRDA;
            end else begin
              k     <= '0;
              state <= EMIT;
            end
          end else begin
            idx   <= idx_inc;
            state <= DRDA;
          end
        end
        EMIT: begin
          bin_q  <= k;
          val_q  <= (k < 6'(mvdh_pkg::VALUE_BINS)) ? value_bins[k[mvdh_pkg::VBIN_W-1:0]]
                                                   : 13'd0;
          if (k < 6'(mvdh_pkg::VALUE_BINS)) begin
            value_bins[k[mvdh_pkg::VBIN_W-1:0]] <= '0;
          end
          dvalid[k] <= 1'b0;
          res_v  <= 1'b1;
          last_q <= (k == 6'(mvdh_pkg::DELTA_BINS - 1));
          k      <= k + 6'd1;
          if (k == 6'(mvdh_pkg::DELTA_BINS - 1)) state <= DONE;
        end
        DONE: begin
          res_v          <= 1'b0;
          cells_loaded   <= '0;
          deltas_counted <= '0;
          dropped        <= 1'b0;
          min_seen       <= {1'b0, {32{1'b1}}};
          max_seen       <= {1'b1, 32'b0};
          state          <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign result_valid = res_v;
  assign bin_index    = bin_q;
  assign value_count  = val_q;
  assign delta_count  = dvb_q ? drd_q : 13'd0;
  assign cell_total   = cells_loaded;
  assign delta_total  = deltas_counted;
  assign overflow     = dropped;
  assign last_result  = last_q;

endmodule

@@ rtl/mvdh_div.sv @@
module mvdh_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mvdh_pkg::NUM_W-1:0]  num,
  input  logic [mvdh_pkg::VAL_W-1:0]  den,
  output mvdh_pkg::div_res_t          res
);

  logic                        run;
  logic [2:0]                  step;
  logic [mvdh_pkg::NUM_W-1:0]  rem;
  logic [mvdh_pkg::NUM_W-1:0]  dsh;
  logic [mvdh_pkg::Q_W-1:0]    quot;
  logic                        done;
  logic                        ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= run && !start && (step == 3'd0);
      if (start) begin
        run  <= 1'b1;
        step <= 3'(mvdh_pkg::Q_W - 1);
      end else if (run) begin
        step <= step - 3'd1;
        if (step == 3'd0) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {den, 5'b0};
      quot <= '0;
    end else if (run) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= {quot[mvdh_pkg::Q_W-2:0], ge};
      dsh  <= {1'b0, dsh[mvdh_pkg::NUM_W-1:1]};
    end
  end

  assign res.done   = done;
  assign res.quot   = quot;
  assign res.rem_nz = (rem != '0);

endmodule
